// ===== rtl/linear_probe_key_set_macros.svh =====
// Assertion macros for the linear probe key set checker.
// Depends on nothing; included by the checker file.
`ifndef LINEAR_PROBE_KEY_SET_MACROS_SVH
`define LINEAR_PROBE_KEY_SET_MACROS_SVH

// Check a consequent in the same cycle as its antecedent.
`define LPKS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("linear_probe_key_set: same-cycle check failed");

// Check a consequent in the cycle after its antecedent.
`define LPKS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("linear_probe_key_set: next-cycle check failed");

`endif

// ===== rtl/lpks_pkg.sv =====
// Shared types and constants of the linear probe key set.
// Depends on nothing; used by the top level and its checker.
package lpks_pkg;

  localparam int unsigned TableSlotsDefault = 8192;
  localparam int unsigned KeyBitsDefault    = 22;
  localparam int unsigned KeyFieldW         = 22;
  localparam logic [31:0] HashMult          = 32'd2654435761;

  localparam logic KIND_MARK   = 1'b0;
  localparam logic KIND_FORGET = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic [KeyFieldW-1:0] key;
  } lpks_in_t;

  typedef struct packed {
    logic first_sight;
    logic table_full;
  } lpks_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_RESP
  } lpks_state_e;

endpackage

// ===== rtl/linear_probe_key_set.sv =====
// Linear probe key set: one request, one result, table in a single RAM.
// Steps: a hash state (bit-serial over the key if TABLE_SLOTS is not a power of two),
// a probe state reading one slot per cycle (one RAM read port, read-modify-write at
// the end), then a response state held until the output register is free, and back
// to idle for a new request; a zero key skips to the response. Reset: control clears
// at once, then a clearing pass writes zero to every slot while in_ready_o stays low.
module linear_probe_key_set #(
  parameter int unsigned TABLE_SLOTS = lpks_pkg::TableSlotsDefault,
  parameter int unsigned KEY_BITS    = lpks_pkg::KeyBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  lpks_pkg::lpks_in_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lpks_pkg::lpks_out_t out_data_o
);
  import lpks_pkg::*;

  localparam int unsigned IDX_W   = $clog2(TABLE_SLOTS);
  localparam bit          IS_POW2 = (TABLE_SLOTS == (1 << IDX_W));
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [IDX_W-1:0] MULT_LO  = HashMult[IDX_W-1:0];
  localparam logic [IDX_W-1:0] MULT_MOD = IDX_W'(64'(HashMult) % 64'(TABLE_SLOTS));
  localparam logic [IDX_W+1:0] N1       = (IDX_W+2)'(TABLE_SLOTS);
  localparam logic [IDX_W+1:0] N2       = (IDX_W+2)'(2 * TABLE_SLOTS);
  localparam logic [4:0]       TOP_BIT  = 5'(KEY_BITS - 1);

  logic [KEY_BITS-1:0] key_slots [TABLE_SLOTS];

  lpks_state_e state_q, state_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic                kind_q, kind_d;
  logic [IDX_W-1:0]    probe_q, probe_d;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    clr_q, clr_d;
  logic [IDX_W-1:0]    hash_q, hash_d;
  logic [4:0]          bit_q, bit_d;
  lpks_out_t           res_q, res_d;
  lpks_out_t           out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [KEY_BITS-1:0] rd_q;
  logic [IDX_W-1:0]    raddr;
  logic                we;
  logic [IDX_W-1:0]    waddr;
  logic [KEY_BITS-1:0] wdata;

  logic [31:0]         in_key_x, key_x;
  logic [KEY_BITS-1:0] in_key;
  logic [2*IDX_W-1:0]  prod;
  logic [IDX_W+1:0]    horner, horner_red;
  logic [IDX_W-1:0]    hash_val;
  logic                hash_fin;
  logic                hit, empty, last, out_free;
  logic [IDX_W-1:0]    next_slot;

  assign in_key_x = 32'(in_data_i.key);
  assign in_key   = in_key_x[KEY_BITS-1:0];
  assign key_x    = 32'(key_q);

  assign prod   = key_x[IDX_W-1:0] * MULT_LO;
  assign horner = {hash_q, 1'b0} + (key_x[bit_q] ? (IDX_W+2)'(MULT_MOD) : '0);
  always_comb begin
    if (horner >= N2) begin
      horner_red = horner - N2;
    end else if (horner >= N1) begin
      horner_red = horner - N1;
    end else begin
      horner_red = horner;
    end
  end
  assign hash_val = IS_POW2 ? prod[IDX_W-1:0] : horner_red[IDX_W-1:0];
  assign hash_fin = IS_POW2 || (bit_q == '0);

  assign hit       = (rd_q == key_q);
  assign empty     = (rd_q == '0);
  assign last      = (cnt_q == LAST_IDX);
  assign next_slot = (probe_q == LAST_IDX) ? '0 : probe_q + 1'b1;
  assign out_free  = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == LAST_IDX) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = (in_key == '0) ? ST_RESP : ST_HASH;
      end
      ST_HASH: begin
        if (hash_fin) state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (hit || empty || last) state_d = ST_RESP;
      end
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    key_d       = key_q;
    kind_d      = kind_q;
    probe_d     = probe_q;
    cnt_d       = cnt_q;
    clr_d       = clr_q;
    hash_d      = hash_q;
    bit_d       = bit_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    raddr       = probe_q;
    we          = 1'b0;
    waddr       = probe_q;
    wdata       = key_q;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
        clr_d = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d  = in_key;
          kind_d = in_data_i.kind;
          hash_d = '0;
          bit_d  = TOP_BIT;
          res_d  = '0;
        end
      end
      ST_HASH: begin
        hash_d = hash_val;
        bit_d  = bit_q - 1'b1;
        if (hash_fin) begin
          raddr   = hash_val;
          probe_d = hash_val;
          cnt_d   = '0;
        end
      end
      ST_PROBE: begin
        if (hit) begin
          if (kind_q == KIND_FORGET) begin
            we    = 1'b1;
            wdata = '0;
          end
        end else if (empty) begin
          if (kind_q == KIND_MARK) begin
            we                = 1'b1;
            res_d.first_sight = 1'b1;
          end
        end else if (last) begin
          res_d.table_full = (kind_q == KIND_MARK);
        end else begin
          raddr   = next_slot;
          probe_d = next_slot;
          cnt_d   = cnt_q + 1'b1;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) key_slots[waddr] <= wdata;
    rd_q <= key_slots[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    kind_q  <= kind_d;
    probe_q <= probe_d;
    cnt_q   <= cnt_d;
    hash_q  <= hash_d;
    bit_q   <= bit_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

endmodule

// ===== rtl/lpks_checker.sv =====
// Port-level checks for the linear probe key set, bound to the top level.
// Depends on lpks_pkg and linear_probe_key_set_macros.svh.
`include "linear_probe_key_set_macros.svh"

module lpks_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input lpks_pkg::lpks_in_t  in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input lpks_pkg::lpks_out_t out_data_o
);
  import lpks_pkg::*;

  logic [1:0] pend_q, pend_d;
  logic       kind_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc && pend_q != 2'd3) begin
      pend_d = pend_q + 1'b1;
    end else if (!in_acc && out_acc && pend_q != 2'd0) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      kind_q <= KIND_MARK;
    end else begin
      pend_q <= pend_d;
      if (in_acc) kind_q <= in_data_i.kind;
    end
  end

  `LPKS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(out_data_o))
  `LPKS_ASSERT_NOW(a_flags_excl, clk_i, rst_ni, out_valid_o,
                   !(out_data_o.first_sight && out_data_o.table_full))
  `LPKS_ASSERT_NOW(a_no_orphan, clk_i, rst_ni, $rose(out_valid_o), pend_q != 2'd0)
  `LPKS_ASSERT_NOW(a_forget_zero, clk_i, rst_ni,
                   $rose(out_valid_o) && pend_q == 2'd1 && kind_q == KIND_FORGET,
                   !out_data_o.first_sight && !out_data_o.table_full)

endmodule

bind linear_probe_key_set lpks_checker u_lpks_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);
